FILE: src/tch_pkg.sv
// tch_pkg: shared constants, types and CORDIC tables for the tilt-compensated
// heading core. Used by tch_sincos, tch_atan2 and tilt_compensated_heading_core.
// No dependencies.
package tch_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int ANGLE_BITS   = 16;
  localparam int TURN_W       = 32;          // internal binary angle, 2^31 = pi
  localparam int CORDIC_ITERS = 30;
  localparam int SC_W         = 32;          // Q30 sine / cosine
  localparam int FRAC_BITS    = 30;
  localparam int PROD_W       = SAMPLE_BITS + SC_W;
  localparam int VEC_W        = PROD_W + 2;  // atan2 operands
  localparam int SUM_W        = 2 * SAMPLE_BITS;
  localparam int SQRT_PRESHIFT = 16;
  localparam int RAD_W        = 64;
  localparam int ROOT_W       = RAD_W / 2;
  localparam int REM_W        = ROOT_W + 3;
  localparam int ISQ_STEPS    = RAD_W / 2;
  localparam int MAG_SHIFT    = 22;
  localparam int NUM_SHIFT    = 30;

  // Pipeline positions (register index from the input register, which is 0)
  localparam int SC_LAST = CORDIC_ITERS + 1;
  localparam int HX_IDX  = SC_LAST + 3;
  localparam int OUT_IDX = HX_IDX + CORDIC_ITERS + 2;

  localparam logic signed [SC_W-1:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic [TURN_W-1:0] HALF_LSB = TURN_W'(1) << (TURN_W - 1 - ANGLE_BITS);

  localparam logic [TURN_W-1:0] ATAN_TURNS [CORDIC_ITERS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef enum logic [1:0] {
    REQ_PITCH   = 2'd0,
    REQ_ROLL    = 2'd1,
    REQ_HEADING = 2'd2
  } req_t;

  typedef struct packed {
    logic [1:0]                    req;
    logic signed [SAMPLE_BITS-1:0] x;
    logic signed [SAMPLE_BITS-1:0] y;
    logic signed [SAMPLE_BITS-1:0] z;
  } side_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } sq_t;

endpackage

FILE: src/tch_sincos.sv
// tch_sincos: two-lane pipelined rotation CORDIC, Q30 cosine and sine of two
// 32-bit binary angles, one stage per iteration. Depends on tch_pkg.
module tch_sincos (
  input  logic                            clk,
  input  logic                            en,
  input  logic [tch_pkg::TURN_W-1:0]      ang_a,
  input  logic [tch_pkg::TURN_W-1:0]      ang_b,
  output logic signed [tch_pkg::SC_W-1:0] cos_a,
  output logic signed [tch_pkg::SC_W-1:0] sin_a,
  output logic signed [tch_pkg::SC_W-1:0] cos_b,
  output logic signed [tch_pkg::SC_W-1:0] sin_b
);
  import tch_pkg::*;

  localparam int LANES = 2;

  logic signed [SC_W-1:0]   x_r    [CORDIC_ITERS+1][LANES];
  logic signed [SC_W-1:0]   y_r    [CORDIC_ITERS+1][LANES];
  logic [TURN_W-1:0]        z_r    [CORDIC_ITERS+1][LANES];
  logic                     flip_r [CORDIC_ITERS+1][LANES];
  logic [TURN_W-1:0]        ang_in [LANES];
  logic [TURN_W-1:0]        z_in   [LANES];
  logic                     flip_in[LANES];

  assign ang_in[0] = ang_a;
  assign ang_in[1] = ang_b;

  // Angles in the left half-plane are turned by pi; results negated at the end
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      flip_in[l] = ang_in[l][TURN_W-1] ^ ang_in[l][TURN_W-2];
      z_in[l]    = flip_in[l] ? {~ang_in[l][TURN_W-1], ang_in[l][TURN_W-2:0]} : ang_in[l];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        x_r[0][l]    <= CORDIC_GAIN;
        y_r[0][l]    <= '0;
        z_r[0][l]    <= z_in[l];
        flip_r[0][l] <= flip_in[l];
      end
      for (int k = 0; k < CORDIC_ITERS; k++) begin
        for (int l = 0; l < LANES; l++) begin
          flip_r[k+1][l] <= flip_r[k][l];
          if (!z_r[k][l][TURN_W-1]) begin
            x_r[k+1][l] <= x_r[k][l] - (y_r[k][l] >>> k);
            y_r[k+1][l] <= y_r[k][l] + (x_r[k][l] >>> k);
            z_r[k+1][l] <= z_r[k][l] - ATAN_TURNS[k];
          end else begin
            x_r[k+1][l] <= x_r[k][l] + (y_r[k][l] >>> k);
            y_r[k+1][l] <= y_r[k][l] - (x_r[k][l] >>> k);
            z_r[k+1][l] <= z_r[k][l] + ATAN_TURNS[k];
          end
        end
      end
    end
  end

  assign cos_a = flip_r[CORDIC_ITERS][0] ? -x_r[CORDIC_ITERS][0] : x_r[CORDIC_ITERS][0];
  assign sin_a = flip_r[CORDIC_ITERS][0] ? -y_r[CORDIC_ITERS][0] : y_r[CORDIC_ITERS][0];
  assign cos_b = flip_r[CORDIC_ITERS][1] ? -x_r[CORDIC_ITERS][1] : x_r[CORDIC_ITERS][1];
  assign sin_b = flip_r[CORDIC_ITERS][1] ? -y_r[CORDIC_ITERS][1] : y_r[CORDIC_ITERS][1];

endmodule

FILE: src/tch_atan2.sv
// tch_atan2: pipelined vectoring CORDIC giving atan2(py, px) as a 32-bit
// binary angle, one stage per iteration. Depends on tch_pkg.
module tch_atan2 (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [tch_pkg::VEC_W-1:0] py,
  input  logic signed [tch_pkg::VEC_W-1:0] px,
  output logic [tch_pkg::TURN_W-1:0]       ang
);
  import tch_pkg::*;

  logic signed [VEC_W-1:0] px_r   [CORDIC_ITERS+1];
  logic signed [VEC_W-1:0] py_r   [CORDIC_ITERS+1];
  logic [TURN_W-1:0]       z_r    [CORDIC_ITERS+1];
  logic                    half_r [CORDIC_ITERS+1];
  logic                    zero_r [CORDIC_ITERS+1];
  logic                    neg;

  assign neg = px[VEC_W-1];

  always_ff @(posedge clk) begin
    if (en) begin
      // negative x: turn the vector by pi and add the half turn at the end
      px_r[0]   <= neg ? -px : px;
      py_r[0]   <= neg ? -py : py;
      z_r[0]    <= '0;
      half_r[0] <= neg;
      zero_r[0] <= (px == '0) && (py == '0);
      for (int k = 0; k < CORDIC_ITERS; k++) begin
        half_r[k+1] <= half_r[k];
        zero_r[k+1] <= zero_r[k];
        if (!py_r[k][VEC_W-1]) begin
          px_r[k+1] <= px_r[k] + (py_r[k] >>> k);
          py_r[k+1] <= py_r[k] - (px_r[k] >>> k);
          z_r[k+1]  <= z_r[k] + ATAN_TURNS[k];
        end else begin
          px_r[k+1] <= px_r[k] - (py_r[k] >>> k);
          py_r[k+1] <= py_r[k] + (px_r[k] >>> k);
          z_r[k+1]  <= z_r[k] - ATAN_TURNS[k];
        end
      end
    end
  end

  assign ang = zero_r[CORDIC_ITERS] ? '0 :
               {half_r[CORDIC_ITERS], {(TURN_W-1){1'b0}}} + z_r[CORDIC_ITERS];

endmodule

FILE: src/tilt_compensated_heading_core.sv
// tilt_compensated_heading_core: pitch, roll and tilt-compensated heading as
// binary angles. Depends on tch_pkg, tch_sincos and tch_atan2.
//
// Usage:
//  - Input channel (in_valid / in_stall): one request per transfer with the
//    request type, a three-axis sample and, for heading, pitch and roll.
//  - Result channel (out_valid / out_stall): one angle per request, in order.
//  - Pipeline: the input transfer reaches out_valid through the 30-stage
//    sine/cosine CORDIC, three multiply/sum stages and the 30-stage atan2
//    CORDIC. The pitch/roll path runs a 32-stage square root alongside.
//  - Throughput: one request per cycle, sustained while no result is held under out_stall.
//  - Stalling: while a result is held at the output under out_stall the whole
//    pipeline freezes and in_stall is raised; nothing is dropped or repeated.
//  - Reset clears all stage valid bits; the block is ready in the next cycle.
//  - Request type 3 yields an angle of 0; atan2 of a zero vector gives 0.
module tilt_compensated_heading_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             in_req_type,
  input  logic signed [tch_pkg::SAMPLE_BITS-1:0] in_vec_x,
  input  logic signed [tch_pkg::SAMPLE_BITS-1:0] in_vec_y,
  input  logic signed [tch_pkg::SAMPLE_BITS-1:0] in_vec_z,
  input  logic signed [tch_pkg::ANGLE_BITS-1:0]  in_pitch_in,
  input  logic signed [tch_pkg::ANGLE_BITS-1:0]  in_roll_in,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [tch_pkg::ANGLE_BITS-1:0]  out_angle_out
);
  import tch_pkg::*;

  logic [OUT_IDX:0]          vld_r;
  logic                      en;
  side_t                     side_r [HX_IDX+1];
  logic signed [ANGLE_BITS-1:0] pitch_r, roll_r;

  // square root path
  logic signed [SAMPLE_BITS-1:0] sq_a;
  logic signed [SUM_W-1:0]       sqa, sqb;
  logic [SUM_W-1:0]              sum_nxt, sum_r;
  sq_t                           sq_init;
  sq_t                           sq_r [ISQ_STEPS];
  logic signed [VEC_W-1:0]       mag_r;

  // heading path
  logic signed [SC_W-1:0]      cos_p, sin_p, cos_r, sin_r;
  logic signed [2*SC_W-1:0]    psr_r, psc_r;
  logic signed [SC_W-1:0]      cp_r, cr_r, sr_r;
  logic signed [SC_W-1:0]      spsr, spcr;
  logic signed [PROD_W-1:0]    tx_r, ty_r, tz_r, uy_r, uz_r;
  logic signed [VEC_W-1:0]     hx_r, hy_r;

  logic signed [VEC_W-1:0]     py_in, px_in;
  logic [TURN_W-1:0]           ang;
  logic [TURN_W-1:0]           rnd;
  logic signed [ANGLE_BITS-1:0] angle_r;

  function automatic sq_t sq_step(sq_t s);
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    sq_t o;
    cur   = {s.rem[REM_W-3:0], s.rad[RAD_W-1 -: 2]};
    trial = {1'b0, s.root, 2'b01};
    o.rad = {s.rad[RAD_W-3:0], 2'b00};
    if (cur >= trial) begin
      o.rem  = cur - trial;
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = cur;
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // Whole pipeline advances unless a finished result is held back
  assign en       = !(vld_r[OUT_IDX] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[OUT_IDX-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= '{req: in_req_type, x: in_vec_x, y: in_vec_y, z: in_vec_z};
      pitch_r   <= in_pitch_in;
      roll_r    <= in_roll_in;
      for (int i = 1; i <= HX_IDX; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  // ---- pitch / roll: sqrt((a^2 + b^2) << 16) ----
  assign sq_a    = (side_r[0].req == REQ_PITCH) ? side_r[0].y : side_r[0].x;
  assign sqa     = sq_a * sq_a;
  assign sqb     = side_r[0].z * side_r[0].z;
  assign sum_nxt = $unsigned(sqa) + $unsigned(sqb);

  assign sq_init.rem  = '0;
  assign sq_init.root = '0;
  assign sq_init.rad  = {{(RAD_W-SUM_W-SQRT_PRESHIFT){1'b0}}, sum_r,
                         {SQRT_PRESHIFT{1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r    <= sum_nxt;
      sq_r[0]  <= sq_step(sq_init);
      for (int k = 1; k < ISQ_STEPS; k++) begin
        sq_r[k] <= sq_step(sq_r[k-1]);
      end
      mag_r <= $signed(VEC_W'({sq_r[ISQ_STEPS-1].root, {MAG_SHIFT{1'b0}}}));
    end
  end

  // ---- heading: rotate the magnetometer vector into the horizontal plane ----
  tch_sincos u_sincos (
    .clk   (clk),
    .en    (en),
    .ang_a ({pitch_r, {(TURN_W-ANGLE_BITS){1'b0}}}),
    .ang_b ({roll_r, {(TURN_W-ANGLE_BITS){1'b0}}}),
    .cos_a (cos_p),
    .sin_a (sin_p),
    .cos_b (cos_r),
    .sin_b (sin_r)
  );

  assign spsr = psr_r[FRAC_BITS+SC_W-1:FRAC_BITS];
  assign spcr = psc_r[FRAC_BITS+SC_W-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      psr_r <= sin_p * sin_r;
      psc_r <= sin_p * cos_r;
      cp_r  <= cos_p;
      cr_r  <= cos_r;
      sr_r  <= sin_r;
      tx_r  <= side_r[SC_LAST+1].x * cp_r;
      ty_r  <= side_r[SC_LAST+1].y * spsr;
      tz_r  <= side_r[SC_LAST+1].z * spcr;
      uy_r  <= side_r[SC_LAST+1].y * cr_r;
      uz_r  <= side_r[SC_LAST+1].z * sr_r;
      hx_r  <= VEC_W'(tx_r) + VEC_W'(ty_r) + VEC_W'(tz_r);
      hy_r  <= VEC_W'(uy_r) - VEC_W'(uz_r);
    end
  end

  // ---- operand select for the shared atan2 ----
  always_comb begin
    py_in = '0;
    px_in = '0;
    case (side_r[HX_IDX].req)
      REQ_PITCH: begin
        py_in = VEC_W'(side_r[HX_IDX].x) <<< NUM_SHIFT;
        px_in = mag_r;
      end
      REQ_ROLL: begin
        py_in = VEC_W'(side_r[HX_IDX].y) <<< NUM_SHIFT;
        px_in = mag_r;
      end
      REQ_HEADING: begin
        py_in = hy_r;
        px_in = hx_r;
      end
      default: begin
        // unused type: zero vector, angle comes out as 0
        py_in = '0;
        px_in = '0;
      end
    endcase
  end

  tch_atan2 u_atan2 (
    .clk (clk),
    .en  (en),
    .py  (py_in),
    .px  (px_in),
    .ang (ang)
  );

  assign rnd = ang + HALF_LSB;

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= $signed(rnd[TURN_W-1 -: ANGLE_BITS]);
    end
  end

  assign out_valid     = vld_r[OUT_IDX];
  assign out_angle_out = angle_r;

`ifndef ASSERT_OFF
  a_freeze_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(vld_r))
    else $error("pipeline moved while the result was stalled");

  a_transfer_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted transfer did not enter the pipeline");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (vld_r == '0))
    else $error("stage valid bits not cleared by reset");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");
`endif

endmodule
